/* hw/rtl/tsgi_pkg.sv */
package tsgi_pkg;

    localparam int unsigned TAG_W       = 16;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned STORE_DEPTH = 64;
    localparam int unsigned ADDR_W      = 6;
    localparam int unsigned DIVISOR_W   = 7;
    localparam int unsigned DATA_W      = TAG_W + TIME_W;

    localparam logic [TIME_W-1:0] MISSING_TIME = '1;

    localparam logic [STATUS_W-1:0] STATUS_RELEASED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_REF   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_FLUSH  = 1'b1;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_DIFF = 9'b000000010,
        ST_ABS  = 9'b000000100,
        ST_DIV  = 9'b000001000,
        ST_STEP = 9'b000010000,
        ST_RD   = 9'b000100000,
        ST_EMIT = 9'b001000000,
        ST_LAST = 9'b010000000,
        ST_DROP = 9'b100000000
    } t_state;

endpackage

/* hw/rtl/tsgi_ram.sv */
module tsgi_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/timestamp_gap_interpolator.sv */
// held or flushed samples stay in ST_IDLE, a drop passes ST_DROP, a direct release ST_LAST
// a timed sample releasing n held samples uses one shared 33-bit adder for difference,
// magnitude, 32 restoring divide steps, step sign and each accumulated time, then ST_LAST
// throughput: one input beat per item, the input is not ready until its results are loaded
// synchronous active-low reset: no reference, empty store, no output beat pending
module timestamp_gap_interpolator #(
    parameter int unsigned MAX_PENDING = 63,
    parameter int unsigned TAG_BITS    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [tsgi_pkg::DATA_W-1:0]   s_axis_tdata,  // sample_tag, sample_time
    input  logic                          s_axis_tuser,  // action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [tsgi_pkg::DATA_W-1:0]   m_axis_tdata,  // out_tag, out_time
    output logic [tsgi_pkg::STATUS_W-1:0] m_axis_tuser,  // status
    output logic                          m_axis_tlast
);
    import tsgi_pkg::*;

    localparam int unsigned STORE_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    t_state                r_state, n_state;
    logic [STORE_W-1:0]    r_tag, n_tag;
    logic [TIME_W-1:0]     r_ts, n_ts;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic                  r_refv, n_refv;
    logic [TIME_W-1:0]     r_ref, n_ref;
    logic [ADDR_W-1:0]     r_count, n_count;
    logic [ADDR_W-1:0]     r_idx, n_idx;
    logic                  r_neg, n_neg;
    logic [TIME_W-1:0]     r_q, n_q;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [4:0]            r_bit, n_bit;
    logic [TIME_W-1:0]     r_step, n_step;
    logic [TIME_W-1:0]     r_acc, n_acc;
    logic                  r_oval, n_oval;
    logic [TAG_W-1:0]      r_otag, n_otag;
    logic [TIME_W-1:0]     r_otime, n_otime;
    logic [STATUS_W-1:0]   r_ostat, n_ostat;
    logic                  r_olast, n_olast;

    logic [TIME_W:0]       add_a, add_b;
    logic                  add_cin;
    logic [TIME_W+1:0]     add_sum;
    logic                  add_carry;
    logic [DIVISOR_W-1:0]  divisor;
    logic [DIVISOR_W:0]    trial;
    logic                  ram_we;
    logic [STORE_W-1:0]    ram_rdata;
    logic [TAG_W-1:0]      in_tag;
    logic [TIME_W-1:0]     in_ts;
    logic                  in_accept;
    logic                  out_free;

    assign in_tag    = s_axis_tdata[TAG_W-1:0];
    assign in_ts     = s_axis_tdata[DATA_W-1:TAG_W];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_oval || m_axis_tready;
    assign divisor   = {1'b0, r_count} + DIVISOR_W'(1);
    assign trial     = {r_rem, r_q[TIME_W-1]};

    // shared adder
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (r_state)
            ST_DIFF: begin
                add_a   = {1'b0, r_ts};
                add_b   = ~{1'b0, r_ref};
                add_cin = 1'b1;
            end
            ST_ABS, ST_STEP: begin
                add_b   = {1'b0, (r_neg ? ~r_q : r_q)};
                add_cin = r_neg;
            end
            ST_DIV: begin
                add_a   = (TIME_W+1)'(trial);
                add_b   = ~((TIME_W+1)'(divisor));
                add_cin = 1'b1;
            end
            ST_EMIT: begin
                add_a   = {1'b0, r_acc};
                add_b   = {1'b0, r_step};
            end
            default: begin
                add_a   = '0;
            end
        endcase
    end

    assign add_sum   = {1'b0, add_a} + {1'b0, add_b} + (TIME_W+2)'(add_cin);
    assign add_carry = add_sum[TIME_W+1];

    tsgi_ram #(
        .WIDTH (STORE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count),
        .i_wdata (in_tag[STORE_W-1:0]),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_tag    = r_tag;
        n_ts     = r_ts;
        n_status = r_status;
        n_refv   = r_refv;
        n_ref    = r_ref;
        n_count  = r_count;
        n_idx    = r_idx;
        n_neg    = r_neg;
        n_q      = r_q;
        n_rem    = r_rem;
        n_bit    = r_bit;
        n_step   = r_step;
        n_acc    = r_acc;
        n_oval   = r_oval && !m_axis_tready;
        n_otag   = r_otag;
        n_otime  = r_otime;
        n_ostat  = r_ostat;
        n_olast  = r_olast;
        ram_we   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_tag = in_tag[STORE_W-1:0];
                    n_ts  = in_ts;
                    if (s_axis_tuser == ACTION_FLUSH) begin
                        n_count = '0;
                        n_refv  = 1'b0;
                    end else if (in_ts == MISSING_TIME || (r_refv && in_ts == r_ref)) begin
                        if (!r_refv) begin
                            n_status = STATUS_NO_REF;
                            n_state  = ST_DROP;
                        end else if (r_count >= ADDR_W'(MAX_PENDING)) begin
                            n_status = STATUS_FULL;
                            n_state  = ST_DROP;
                        end else begin
                            ram_we  = 1'b1;
                            n_count = r_count + ADDR_W'(1);
                        end
                    end else if (r_refv && r_count != '0) begin
                        n_state = ST_DIFF;
                    end else begin
                        n_state = ST_LAST;
                    end
                end
            end
            ST_DIFF: begin
                n_q     = add_sum[TIME_W-1:0];
                n_neg   = !add_carry;
                n_state = ST_ABS;
            end
            ST_ABS: begin
                n_q     = add_sum[TIME_W-1:0];
                n_neg   = r_neg;
                n_rem   = '0;
                n_bit   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem = add_carry ? add_sum[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                n_q   = {r_q[TIME_W-2:0], add_carry};
                n_bit = r_bit + 5'd1;
                if (r_bit == 5'd31) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                n_step  = add_sum[TIME_W-1:0];
                n_acc   = r_ref;
                n_idx   = '0;
                n_state = ST_RD;
            end
            ST_RD: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_oval  = 1'b1;
                    n_otag  = TAG_W'(ram_rdata);
                    n_otime = add_sum[TIME_W-1:0];
                    n_ostat = STATUS_RELEASED;
                    n_olast = 1'b0;
                    n_acc   = add_sum[TIME_W-1:0];
                    if (r_idx == r_count - ADDR_W'(1)) begin
                        n_state = ST_LAST;
                    end else begin
                        n_idx   = r_idx + ADDR_W'(1);
                        n_state = ST_RD;
                    end
                end
            end
            ST_LAST: begin
                if (out_free) begin
                    n_oval  = 1'b1;
                    n_otag  = TAG_W'(r_tag);
                    n_otime = r_ts;
                    n_ostat = STATUS_RELEASED;
                    n_olast = 1'b1;
                    n_ref   = r_ts;
                    n_refv  = 1'b1;
                    n_count = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_DROP: begin
                if (out_free) begin
                    n_oval  = 1'b1;
                    n_otag  = TAG_W'(r_tag);
                    n_otime = '0;
                    n_ostat = r_status;
                    n_olast = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_refv  <= 1'b0;
            r_ref   <= '0;
            r_count <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_refv  <= n_refv;
            r_ref   <= n_ref;
            r_count <= n_count;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag    <= n_tag;
        r_ts     <= n_ts;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_neg    <= n_neg;
        r_q      <= n_q;
        r_rem    <= n_rem;
        r_bit    <= n_bit;
        r_step   <= n_step;
        r_acc    <= n_acc;
        r_otag   <= n_otag;
        r_otime  <= n_otime;
        r_ostat  <= n_ostat;
        r_olast  <= n_olast;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = {r_otime, r_otag};
    assign m_axis_tuser  = r_ostat;
    assign m_axis_tlast  = r_olast;

endmodule

/* hw/rtl/tsgi_checker.sv */
module tsgi_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [tsgi_pkg::DATA_W-1:0]   m_axis_tdata,
    input logic [tsgi_pkg::STATUS_W-1:0] m_axis_tuser,
    input logic                          m_axis_tlast
);
    import tsgi_pkg::*;

    // reset leaves the block ready and empty
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready && !m_axis_tvalid)
        else $error("block not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

    // drops carry zero time and end the run
    a_drop_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != STATUS_RELEASED |->
            m_axis_tlast && m_axis_tdata[DATA_W-1:TAG_W] == '0
            && (m_axis_tuser == STATUS_NO_REF || m_axis_tuser == STATUS_FULL))
        else $error("malformed drop beat");

    a_held_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == STATUS_RELEASED)
        else $error("non-last beat is not a release");

    a_no_missing_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == STATUS_RELEASED |->
            m_axis_tdata[DATA_W-1:TAG_W] != MISSING_TIME)
        else $error("released beat with missing time");

endmodule

bind timestamp_gap_interpolator tsgi_checker u_tsgi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
